@@ rtl/sps_pkg.sv @@
// Package: types, constants and codes for the strict priority task scheduler.
package sps_pkg;

    localparam int MAX_TASKS       = 4096;
    localparam int PRIORITY_LEVELS = 8;
    localparam int ID_W            = $clog2(MAX_TASKS);
    localparam int CNT_W           = $clog2(MAX_TASKS + 1);
    localparam int LVL_W           = $clog2(PRIORITY_LEVELS);
    localparam int CFG_W           = 13;
    localparam logic [CFG_W-1:0] MAX_RUN_RESET   = 13'd32;
    localparam logic [CFG_W-1:0] MAX_RUN_DEFAULT = 13'd32;

    // slot record packing: {cancel_mark, slot_state}
    localparam int SLOT_W = 4;

    typedef enum logic [1:0] {
        OP_SUBMIT   = 2'd0,
        OP_CANCEL   = 2'd1,
        OP_QUERY    = 2'd2,
        OP_COMPLETE = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_QUEUED    = 3'd0,
        ST_RUNNING   = 3'd1,
        ST_COMPLETED = 3'd2,
        ST_FAILED    = 3'd3,
        ST_CANCELLED = 3'd4
    } task_state_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_OVERFLOW = 2'd1,
        STAT_BAD      = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_ID,
        S_WAIT_ID,
        S_EXEC,
        S_LINK,
        S_DISP_CHK,
        S_POP,
        S_POP_WAIT,
        S_POP_EVAL,
        S_OUT
    } fsm_t;

endpackage

@@ rtl/sps_ram.sv @@
// Generic single-port RAM with registered read.
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ rtl/strict_priority_task_scheduler.sv @@
// Top level: strict priority task scheduler with linked FIFOs per level.
//
//  channel  | dir | handshake             | payload
//  s_       | in  | s_tvalid / s_tready   | tdata {op, priority_req, task_id, task_ok}
//  m_       | out | m_tvalid / m_tready   | tdata {status, result_id, task_state,
//           |     |                       |        dispatch_valid, dispatch_id}
//  cfg_     | in  | cfg_valid / cfg_ready | max_running (13 bits)
//
// An item takes longer for each cancelled head dropped; its timing is set by
// the single slot-record memory port and the link memory port, which the
// sequencer uses one access at a time.
// Reset is synchronous; the memories need no clearing.
// The block takes no item while one is in work or its result is not yet taken.
module strict_priority_task_scheduler (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // op[1:0], priority_req[9:2], task_id[21:10], task_ok[22]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // status[1:0], result_id[13:2], task_state[16:14],
                                   // dispatch_valid[17], dispatch_id[29:18]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [12:0] cfg_data
);
    import sps_pkg::*;

    fsm_t state_reg, state_next;

    logic [CFG_W-1:0] max_run_reg;
    logic [1:0]       op_reg;
    logic [LVL_W-1:0] lvl_reg;
    logic [ID_W-1:0]  id_reg;
    logic             ok_reg;
    logic             known_reg;

    logic [PRIORITY_LEVELS-1:0] nonempty_reg, nonempty_next;
    logic [ID_W-1:0] head_reg [PRIORITY_LEVELS];
    logic [ID_W-1:0] tail_reg [PRIORITY_LEVELS];
    logic [CNT_W-1:0] used_reg, running_reg;

    logic [1:0]      stat_reg;
    logic [ID_W-1:0] rid_reg;
    logic [2:0]      tst_reg;
    logic            dv_reg;
    logic [ID_W-1:0] did_reg;
    logic [ID_W-1:0] pop_id_reg;
    logic [LVL_W-1:0] pop_lvl_reg;
    logic            pop_last_reg;

    // memories
    logic              srec_we, link_we;
    logic [ID_W-1:0]   srec_addr, link_addr;
    logic [SLOT_W-1:0] srec_wdata, srec_rdata;
    logic [ID_W-1:0]   link_wdata, link_rdata;

    sps_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_TASKS)) u_srec (
        .aclk(aclk), .we(srec_we), .addr(srec_addr), .wdata(srec_wdata), .rdata(srec_rdata)
    );
    sps_ram #(.WIDTH(ID_W), .DEPTH(MAX_TASKS)) u_link (
        .aclk(aclk), .we(link_we), .addr(link_addr), .wdata(link_wdata), .rdata(link_rdata)
    );

    logic [CNT_W-1:0] limit;
    assign limit = (max_run_reg == '0) ? CNT_W'(MAX_RUN_DEFAULT) : CNT_W'(max_run_reg);

    // highest non-empty level
    logic             any_ne;
    logic [LVL_W-1:0] top_lvl;
    always_comb begin
        any_ne  = 1'b0;
        top_lvl = '0;
        for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            if (nonempty_reg[i]) begin
                any_ne  = 1'b1;
                top_lvl = LVL_W'(i);
            end
        end
    end

    logic [2:0] cur_st;
    logic       cur_mark;
    assign cur_st   = srec_rdata[2:0];
    assign cur_mark = srec_rdata[3];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign m_tvalid  = (state_reg == S_OUT);
    assign m_tdata   = {2'b00, did_reg, dv_reg, tst_reg, rid_reg, stat_reg};

    // head/tail update requests
    logic            ht_we;
    logic [LVL_W-1:0] ht_lvl;
    logic            h_we, t_we;
    logic [ID_W-1:0] h_val;
    logic [CNT_W-1:0] used_next, running_next;
    logic [1:0]      stat_next;
    logic [ID_W-1:0] rid_next, did_next, pop_id_next;
    logic [2:0]      tst_next;
    logic            dv_next, pop_last_next;
    logic [LVL_W-1:0] pop_lvl_next;

    always_comb begin
        state_next    = state_reg;
        srec_we       = 1'b0;
        srec_addr     = id_reg;
        srec_wdata    = '0;
        link_we       = 1'b0;
        link_addr     = tail_reg[lvl_reg];
        link_wdata    = id_reg;
        nonempty_next = nonempty_reg;
        ht_we         = 1'b0;
        ht_lvl        = lvl_reg;
        h_we          = 1'b0;
        t_we          = 1'b0;
        h_val         = id_reg;
        used_next     = used_reg;
        running_next  = running_reg;
        stat_next     = stat_reg;
        rid_next      = rid_reg;
        tst_next      = tst_reg;
        dv_next       = dv_reg;
        did_next      = did_reg;
        pop_id_next   = pop_id_reg;
        pop_lvl_next  = pop_lvl_reg;
        pop_last_next = pop_last_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_RD_ID;
                end
            end
            S_RD_ID: begin
                stat_next = STAT_OK;
                rid_next  = id_reg;
                tst_next  = ST_QUEUED;
                dv_next   = 1'b0;
                did_next  = '0;
                if (op_t'(op_reg) == OP_SUBMIT) begin
                    state_next = S_EXEC;
                end else begin
                    state_next = S_WAIT_ID;
                end
            end
            S_WAIT_ID: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                unique case (op_t'(op_reg))
                    OP_SUBMIT: begin
                        if (used_reg >= CNT_W'(MAX_TASKS)) begin
                            stat_next  = STAT_OVERFLOW;
                            rid_next   = '0;
                            state_next = S_OUT;
                        end else begin
                            rid_next   = used_reg[ID_W-1:0];
                            srec_addr  = used_reg[ID_W-1:0];
                            srec_we    = 1'b1;
                            srec_wdata = {1'b0, ST_QUEUED};
                            used_next  = used_reg + 1'b1;
                            ht_we      = 1'b1;
                            t_we       = 1'b1;
                            h_val      = used_reg[ID_W-1:0];
                            if (nonempty_reg[lvl_reg]) begin
                                link_we    = 1'b1;
                                link_wdata = used_reg[ID_W-1:0];
                            end else begin
                                h_we = 1'b1;
                            end
                            nonempty_next[lvl_reg] = 1'b1;
                            state_next = S_DISP_CHK;
                        end
                    end
                    OP_CANCEL: begin
                        state_next = S_OUT;
                        if (!known_reg) begin
                            stat_next = STAT_BAD;
                        end else if (cur_st == ST_COMPLETED || cur_st == ST_FAILED ||
                                     cur_st == ST_CANCELLED) begin
                            stat_next = STAT_BAD;
                            tst_next  = cur_st;
                        end else begin
                            srec_we = 1'b1;
                            if (cur_st == ST_QUEUED) begin
                                srec_wdata = {1'b1, ST_CANCELLED};
                                tst_next   = ST_CANCELLED;
                            end else begin
                                srec_wdata = {1'b1, cur_st};
                                tst_next   = cur_st;
                            end
                        end
                    end
                    OP_QUERY: begin
                        state_next = S_OUT;
                        if (known_reg) begin
                            tst_next = cur_st;
                        end else begin
                            stat_next = STAT_BAD;
                        end
                    end
                    OP_COMPLETE: begin
                        state_next = S_DISP_CHK;
                        if (known_reg && cur_st == ST_RUNNING) begin
                            srec_we    = 1'b1;
                            srec_wdata = {cur_mark, ok_reg ? ST_COMPLETED : ST_FAILED};
                            tst_next   = ok_reg ? ST_COMPLETED : ST_FAILED;
                            if (running_reg != '0) begin
                                running_next = running_reg - 1'b1;
                            end
                        end else begin
                            stat_next = STAT_BAD;
                            tst_next  = known_reg ? cur_st : ST_QUEUED;
                        end
                    end
                    default: state_next = S_OUT;
                endcase
            end
            S_DISP_CHK: begin
                if (running_reg >= limit || !any_ne) begin
                    state_next = S_OUT;
                end else begin
                    pop_lvl_next  = top_lvl;
                    pop_id_next   = head_reg[top_lvl];
                    pop_last_next = (head_reg[top_lvl] == tail_reg[top_lvl]);
                    state_next    = S_POP;
                end
            end
            S_POP: begin
                srec_addr  = pop_id_reg;
                link_addr  = pop_id_reg;
                state_next = S_POP_WAIT;
            end
            S_POP_WAIT: begin
                srec_addr  = pop_id_reg;
                link_addr  = pop_id_reg;
                state_next = S_POP_EVAL;
            end
            S_POP_EVAL: begin
                srec_addr = pop_id_reg;
                link_addr = pop_id_reg;
                ht_lvl    = pop_lvl_reg;
                if (pop_last_reg) begin
                    nonempty_next[pop_lvl_reg] = 1'b0;
                end else begin
                    ht_we = 1'b1;
                    h_we  = 1'b1;
                    h_val = link_rdata;
                end
                srec_we = 1'b1;
                if (cur_mark) begin
                    srec_wdata = {1'b1, ST_CANCELLED};
                    state_next = S_DISP_CHK;
                end else begin
                    srec_wdata   = {1'b0, ST_RUNNING};
                    running_next = running_reg + 1'b1;
                    dv_next      = 1'b1;
                    did_next     = pop_id_reg;
                    state_next   = S_OUT;
                end
                // the addressed task itself may have changed
                if (pop_id_reg == rid_reg) begin
                    tst_next = cur_mark ? ST_CANCELLED : ST_RUNNING;
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            nonempty_reg <= '0;
            used_reg     <= '0;
            running_reg  <= '0;
            max_run_reg  <= MAX_RUN_RESET;
        end else begin
            state_reg    <= state_next;
            nonempty_reg <= nonempty_next;
            used_reg     <= used_next;
            running_reg  <= running_next;
            if (cfg_valid && cfg_ready) begin
                max_run_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg    <= s_tdata[1:0];
            lvl_reg   <= (s_tdata[9:2] > 8'(PRIORITY_LEVELS - 1))
                         ? LVL_W'(PRIORITY_LEVELS - 1) : s_tdata[2 +: LVL_W];
            id_reg    <= s_tdata[21:10];
            ok_reg    <= s_tdata[22];
            known_reg <= (CNT_W'(s_tdata[21:10]) < used_reg);
        end
        if (ht_we) begin
            if (h_we) begin
                head_reg[ht_lvl] <= h_val;
            end
            if (t_we) begin
                tail_reg[ht_lvl] <= h_val;
            end
        end
        stat_reg     <= stat_next;
        rid_reg      <= rid_next;
        tst_reg      <= tst_next;
        dv_reg       <= dv_next;
        did_reg      <= did_next;
        pop_id_reg   <= pop_id_next;
        pop_lvl_reg  <= pop_lvl_next;
        pop_last_reg <= pop_last_next;
    end

    // running count never exceeds the slots handed out
    a_run_le_used: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg <= used_reg) else $error("running count above used slots");

    // a dispatch on the way out is flagged in the result
    a_disp_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_POP_EVAL && state_next == S_OUT) |=> dv_reg)
        else $error("dispatch not flagged");

    // result held while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed under stall");

    // input is never taken while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input ready with result pending");

endmodule

@@ tb/sv/strict_priority_task_scheduler_tb.sv @@
// Testbench for the strict priority task scheduler: directed table and random traffic.
`timescale 1ns / 1ps

module strict_priority_task_scheduler_tb;
    import sps_pkg::*;

    typedef struct packed {
        status_t     st;
        logic [11:0] rid;
        task_state_t ts;
        logic        dv;
        logic [11:0] did;
    } sched_res_t;

    typedef struct {
        op_t         op;
        logic [7:0]  prio;
        logic [11:0] id;
        logic        ok;
        bit          typed;
        sched_res_t  want;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [12:0] cfg_data;

    // scheduler shadow state
    task_state_t slot_st   [MAX_TASKS];
    bit          slot_mark [MAX_TASKS];
    logic [11:0] slot_link [MAX_TASKS];
    logic [11:0] lvl_head  [PRIORITY_LEVELS];
    logic [11:0] lvl_tail  [PRIORITY_LEVELS];
    bit   [7:0]  lvl_busy;
    int          slots_taken;
    int          n_running;
    int          run_limit_reg;
    int          running_ids[$];

    sched_res_t  pending_results[$];
    int          n_err;
    int          send_idle_pct;
    int          recv_idle_pct;

    strict_priority_task_scheduler i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    task automatic start_next(output logic dv, output logic [11:0] did);
        int lim;
        int lvl;
        logic [11:0] s;
        dv  = 1'b0;
        did = '0;
        lim = (run_limit_reg == 0) ? 32 : run_limit_reg;
        if (n_running >= lim) return;
        forever begin
            lvl = -1;
            for (int l = PRIORITY_LEVELS - 1; l >= 0; l--)
                if (lvl < 0 && lvl_busy[l]) lvl = l;
            if (lvl < 0) return;
            s = lvl_head[lvl];
            if (s == lvl_tail[lvl]) lvl_busy[lvl] = 1'b0;
            else lvl_head[lvl] = slot_link[s];
            if (slot_mark[s]) begin
                slot_st[s] = ST_CANCELLED;   // cancelled head dropped
            end else begin
                slot_st[s] = ST_RUNNING;
                n_running++;
                running_ids.push_back(s);
                dv  = 1'b1;
                did = s;
                return;
            end
        end
    endtask

    task automatic predict_result(input op_t op, input logic [7:0] prio, input logic [11:0] id,
                                  input logic ok, output sched_res_t r);
        bit known;
        int lvl;
        int s;
        r = '{STAT_OK, id, ST_QUEUED, 1'b0, 12'd0};
        known = id < slots_taken;
        case (op)
            OP_SUBMIT: begin
                if (slots_taken >= MAX_TASKS) begin
                    r.st  = STAT_OVERFLOW;
                    r.rid = '0;
                end else begin
                    s = slots_taken++;
                    lvl = (prio > PRIORITY_LEVELS - 1) ? PRIORITY_LEVELS - 1 : prio;
                    slot_st[s]   = ST_QUEUED;
                    slot_mark[s] = 1'b0;
                    if (lvl_busy[lvl]) slot_link[lvl_tail[lvl]] = 12'(s);
                    else lvl_head[lvl] = 12'(s);
                    lvl_tail[lvl] = 12'(s);
                    lvl_busy[lvl] = 1'b1;
                    start_next(r.dv, r.did);
                    r.rid = 12'(s);
                    r.ts  = slot_st[s];
                end
            end
            OP_CANCEL: begin
                if (!known) begin
                    r.st = STAT_BAD;
                end else begin
                    if (slot_st[id] inside {ST_COMPLETED, ST_FAILED, ST_CANCELLED}) begin
                        r.st = STAT_BAD;
                    end else begin
                        slot_mark[id] = 1'b1;
                        if (slot_st[id] == ST_QUEUED) slot_st[id] = ST_CANCELLED;
                    end
                    r.ts = slot_st[id];
                end
            end
            OP_QUERY: begin
                if (known) r.ts = slot_st[id];
                else r.st = STAT_BAD;
            end
            default: begin
                if (known && slot_st[id] == ST_RUNNING) begin
                    slot_st[id] = ok ? ST_COMPLETED : ST_FAILED;
                    if (n_running > 0) n_running--;
                    foreach (running_ids[i])
                        if (running_ids[i] == id) begin
                            running_ids.delete(i);
                            break;
                        end
                end else begin
                    r.st = STAT_BAD;
                end
                start_next(r.dv, r.did);
                r.ts = known ? slot_st[id] : ST_QUEUED;
            end
        endcase
    endtask

    // called at a falling edge; returns at a falling edge with s_tvalid still high
    task automatic send_item(input op_t op, input logic [7:0] prio, input logic [11:0] id,
                             input logic ok, input bit typed, input sched_res_t want);
        sched_res_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, ok, id, prio, op};
        do @(posedge aclk); while (!s_tready);
        predict_result(op, prio, id, ok, r);
        pending_results.push_back(typed ? want : r);
        @(negedge aclk);
    endtask

    task automatic write_limit(input logic [12:0] val);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        run_limit_reg = val;
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic random_items(input int count);
        op_t op;
        logic [11:0] id;
        int pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            op = (pick < 35) ? OP_SUBMIT : (pick < 50) ? OP_CANCEL :
                 (pick < 65) ? OP_QUERY : OP_COMPLETE;
            pick = $urandom_range(99);
            if (pick < 10 || slots_taken == 0)
                id = 12'($urandom);
            else if (op == OP_COMPLETE && pick < 75 && running_ids.size() != 0)
                id = 12'(running_ids[$urandom_range(running_ids.size() - 1)]);
            else
                id = 12'($urandom_range(slots_taken - 1));
            send_item(op, 8'($urandom), id, 1'($urandom), 1'b0, '0);
        end
    endtask

    // result side: ready changes on the falling edge, transactions checked on the rising edge
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        sched_res_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result transaction %h", m_tdata);
                n_err++;
            end else begin
                e = pending_results.pop_front();
                if (m_tdata[1:0] !== e.st) begin
                    $error("status: expected %0d, got %0d", e.st, m_tdata[1:0]);
                    n_err++;
                end
                if (m_tdata[13:2] !== e.rid) begin
                    $error("result_id: expected %0d, got %0d", e.rid, m_tdata[13:2]);
                    n_err++;
                end
                if (m_tdata[16:14] !== e.ts) begin
                    $error("task_state: expected %0d, got %0d", e.ts, m_tdata[16:14]);
                    n_err++;
                end
                if (m_tdata[17] !== e.dv) begin
                    $error("dispatch_valid: expected %0d, got %0d", e.dv, m_tdata[17]);
                    n_err++;
                end
                if (m_tdata[29:18] !== e.did) begin
                    $error("dispatch_id: expected %0d, got %0d", e.did, m_tdata[29:18]);
                    n_err++;
                end
            end
        end
    end

    initial begin
        dir_row_t tab[] = '{
            '{OP_QUERY,    8'd0,   12'd0,    1'b0, 1'b1, '{STAT_BAD, 12'd0, ST_QUEUED, 1'b0, 12'd0}},
            '{OP_CANCEL,   8'd255, 12'd0,    1'b1, 1'b1, '{STAT_BAD, 12'd0, ST_QUEUED, 1'b0, 12'd0}},
            '{OP_COMPLETE, 8'd0,   12'd4095, 1'b1, 1'b1,
              '{STAT_BAD, 12'd4095, ST_QUEUED, 1'b0, 12'd0}},
            '{OP_SUBMIT,   8'd255, 12'd4095, 1'b0, 1'b1, '{STAT_OK, 12'd0, ST_RUNNING, 1'b1, 12'd0}},
            '{OP_SUBMIT,   8'd5,   12'd0,    1'b0, 1'b1, '{STAT_OK, 12'd1, ST_QUEUED, 1'b0, 12'd0}},
            '{OP_SUBMIT,   8'd7,   12'd0,    1'b0, 1'b1, '{STAT_OK, 12'd2, ST_QUEUED, 1'b0, 12'd0}},
            '{OP_SUBMIT,   8'd5,   12'd0,    1'b0, 1'b1, '{STAT_OK, 12'd3, ST_QUEUED, 1'b0, 12'd0}},
            '{OP_CANCEL,   8'd0,   12'd2,    1'b0, 1'b1, '{STAT_OK, 12'd2, ST_CANCELLED, 1'b0, 12'd0}},
            '{OP_CANCEL,   8'd0,   12'd0,    1'b0, 1'b1, '{STAT_OK, 12'd0, ST_RUNNING, 1'b0, 12'd0}},
            '{OP_QUERY,    8'd0,   12'd1,    1'b0, 1'b1, '{STAT_OK, 12'd1, ST_QUEUED, 1'b0, 12'd0}},
            // cancelled head at level 7 is dropped, slot 1 starts
            '{OP_COMPLETE, 8'd0,   12'd0,    1'b1, 1'b1, '{STAT_OK, 12'd0, ST_COMPLETED, 1'b1, 12'd1}},
            '{OP_CANCEL,   8'd0,   12'd0,    1'b0, 1'b1, '{STAT_BAD, 12'd0, ST_COMPLETED, 1'b0, 12'd0}},
            '{OP_COMPLETE, 8'd0,   12'd0,    1'b1, 1'b1, '{STAT_BAD, 12'd0, ST_COMPLETED, 1'b0, 12'd0}},
            '{OP_COMPLETE, 8'd0,   12'd1,    1'b0, 1'b1, '{STAT_OK, 12'd1, ST_FAILED, 1'b1, 12'd3}},
            '{OP_QUERY,    8'd0,   12'd2,    1'b0, 1'b0, '0},
            '{OP_SUBMIT,   8'd0,   12'd0,    1'b0, 1'b0, '0},
            '{OP_COMPLETE, 8'd0,   12'd3,    1'b1, 1'b0, '0},
            '{OP_QUERY,    8'd0,   12'd4,    1'b0, 1'b0, '0},
            '{OP_SUBMIT,   8'd8,   12'd0,    1'b0, 1'b0, '0},
            '{OP_QUERY,    8'd0,   12'd4095, 1'b0, 1'b1,
              '{STAT_BAD, 12'd4095, ST_QUEUED, 1'b0, 12'd0}}
        };
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        n_err     = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        lvl_busy      = '0;
        slots_taken   = 0;
        n_running     = 0;
        run_limit_reg = 32;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_limit(13'd1);
        send_idle_pct = 24;
        recv_idle_pct = 70;
        foreach (tab[i])
            send_item(tab[i].op, tab[i].prio, tab[i].id, tab[i].ok, tab[i].typed, tab[i].want);

        write_limit(13'd0);          // zero acts as the default limit
        random_items(530);
        send_idle_pct = 70;
        recv_idle_pct = 24;
        write_limit(13'd1);
        random_items(530);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(13'($urandom_range(8, 2)));
        random_items(540);

        send_item(OP_QUERY, 8'd0, 12'd4095, 1'b0, 1'b0, '0);
        send_item(OP_COMPLETE, 8'd0, 12'd4095, 1'b1, 1'b0, '0);
        send_item(OP_CANCEL, 8'd0, 12'd4094, 1'b0, 1'b0, '0);
        random_items(40);
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (n_err == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
